@@ hw/rtl/histogram_binning_engine_macros.svh @@
// Assertion macros for the histogram binning engine checker.
// Depends on nothing; included by the checker file.
`ifndef HISTOGRAM_BINNING_ENGINE_MACROS_SVH
`define HISTOGRAM_BINNING_ENGINE_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define HBE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form on the block's own clock and reset.
`define HBE_ASSERT(lbl, prop, msg) `HBE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/hbe_pkg.sv @@
// Shared types and constants for the histogram binning engine.
// No dependencies; used by hbe_front, hbe_back and the top level.
`timescale 1ns / 1ps

package hbe_pkg;

  // Command codes as carried on func_i.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // One classified command word as it travels through the queue.
  typedef struct packed {
    op_e                op;
    logic signed [31:0] sample;
    logic [6:0]         bin_index;
  } item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [31:0] left_edge;
    logic [30:0]        bin_step;
    logic [30:0]        inv_bin_step;
    logic [7:0]         bins_in_use;
  } cfg_t;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 4'd3;

  localparam logic signed [31:0] RST_LEFT_EDGE   = 32'sd0;
  localparam logic [30:0]        RST_BIN_STEP    = 31'd65536;
  localparam logic [30:0]        RST_INV_WIDTH   = 31'd65536;
  localparam logic [7:0]         RST_BINS_IN_USE = 8'd100;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // x / 1000 for any 32-bit unsigned x: (x * DIV1000_MAGIC) >> DIV1000_SHIFT
  localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
  localparam int unsigned DIV1000_SHIFT = 38;

endpackage

@@ hw/rtl/hbe_front.sv @@
// Front end: takes command words, decodes the function code and queues them.
// Depends on hbe_pkg.
`timescale 1ns / 1ps

module hbe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] sample_i,
  input  logic [6:0]         bin_index_i,
  input  logic               hold_i,
  output logic               busy_o,
  output hbe_pkg::item_t     item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);

  hbe_pkg::item_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;
  hbe_pkg::op_e   op;

  always_comb begin
    unique case (func_i)
      2'd0:    op = hbe_pkg::OP_ADD;
      2'd1:    op = hbe_pkg::OP_READ;
      2'd2:    op = hbe_pkg::OP_CLEAR;
      default: op = hbe_pkg::OP_NOP;
    endcase
  end

  assign busy_o       = hold_i || (fill_q == 2'd2);
  assign push         = start_i && !busy_o;
  assign item_valid_o = (fill_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op, sample: sample_i, bin_index: bin_index_i};
    end
  end

endmodule

@@ hw/rtl/hbe_back.sv @@
// Back end: sequencer, bin store, outlier counters, extremes and result regs.
// Depends on hbe_pkg.
`timescale 1ns / 1ps

module hbe_back #(
  parameter int unsigned MAX_BINS   = 128,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbe_pkg::cfg_t      cfg_i,
  input  hbe_pkg::item_t     item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  output logic               init_busy_o,
  output logic               done_o,
  output logic [31:0]        bin_count_o,
  output logic signed [31:0] bin_center_o,
  output logic [31:0]        below_count_o,
  output logic [31:0]        above_count_o,
  output logic signed [31:0] data_min_o,
  output logic signed [31:0] data_max_o,
  output logic signed [31:0] auto_upper_bound_o
);

  localparam int unsigned AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NBW = $clog2(MAX_BINS + 1);
  localparam int unsigned IW  = (AW > 7) ? AW : 7;
  localparam int unsigned CX  = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_RMW,
    ST_AUB,
    ST_FIN,
    ST_CLR
  } state_e;

  function automatic logic [31:0] cnt_out(input logic [COUNT_BITS-1:0] c);
    logic [CX-1:0] e;
    e = CX'(c);
    return (e > CX'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh00_7FFF_FFFF) return hbe_pkg::S32_MAX;
    if (v < -40'sh00_8000_0000) return hbe_pkg::S32_MIN;
    return v[31:0];
  endfunction

  state_e                  state_q;
  logic                    init_q;
  hbe_pkg::op_e            op_q;
  logic signed [32:0]      diff_q;
  logic [62:0]             prod_q;
  logic [37:0]             cprod_q;
  logic                    in_range_q;
  logic [AW-1:0]           addr_q;
  logic [AW-1:0]           clr_ptr_q;
  logic [COUNT_BITS-1:0]   below_q, above_q;
  logic signed [31:0]      min_q, max_q;
  logic [60:0]             aprod_q;
  logic                    aneg_q;
  logic [31:0]             count_q;
  logic signed [31:0]      center_q;
  logic signed [31:0]      aub_q;
  logic                    done_q;

  // Bin store: one write and one registered read per cycle.
  logic [COUNT_BITS-1:0]   mem_q [MAX_BINS];
  logic [COUNT_BITS-1:0]   rdata_q;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [COUNT_BITS-1:0]   wr_data;

  logic                    pop;
  logic [IW-1:0]           bi_ext;
  logic [NBW-1:0]          nb;
  logic signed [32:0]      range_w, range_neg;
  logic [31:0]             mag;
  logic [22:0]             quot;
  logic signed [39:0]      q_signed;
  logic signed [39:0]      center_sum;

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign init_busy_o  = init_q;
  assign bi_ext       = IW'(item_i.bin_index);

  // Bins in use clamped to [1, MAX_BINS].
  always_comb begin
    if (cfg_i.bins_in_use == 8'd0) begin
      nb = NBW'(1);
    end else if (32'(cfg_i.bins_in_use) > MAX_BINS) begin
      nb = NBW'(MAX_BINS);
    end else begin
      nb = NBW'(cfg_i.bins_in_use);
    end
  end

  always_comb begin
    range_w    = {max_q[31], max_q} - {min_q[31], min_q};
    range_neg  = -range_w;
    mag        = range_w[32] ? range_neg[31:0] : range_w[31:0];
    quot       = aprod_q[60:hbe_pkg::DIV1000_SHIFT];
    q_signed   = aneg_q ? -40'(quot) : 40'(quot);
    center_sum = 40'(cfg_i.left_edge) + 40'(cprod_q) + 40'(cfg_i.bin_step[30:1]);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = bi_ext[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = inc_sat(rdata_q);
    unique case (state_q)
      ST_IDLE: begin
        rd_en = pop && (item_i.op == hbe_pkg::OP_READ);
      end
      ST_IDX: begin
        rd_en   = (prod_q[62:32] < 31'(nb));
        rd_addr = prod_q[32 +: AW];
      end
      ST_RMW: begin
        wr_en = (op_q == hbe_pkg::OP_ADD);
      end
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ptr_q;
        wr_data = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      init_q     <= 1'b1;
      op_q       <= hbe_pkg::OP_NOP;
      diff_q     <= '0;
      prod_q     <= '0;
      cprod_q    <= '0;
      in_range_q <= 1'b0;
      addr_q     <= '0;
      clr_ptr_q  <= '0;
      below_q    <= '0;
      above_q    <= '0;
      min_q      <= hbe_pkg::S32_MAX;
      max_q      <= hbe_pkg::S32_MIN;
      aprod_q    <= '0;
      aneg_q     <= 1'b0;
      count_q    <= '0;
      center_q   <= '0;
      aub_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            op_q     <= item_i.op;
            count_q  <= '0;
            center_q <= '0;
            unique case (item_i.op)
              hbe_pkg::OP_ADD: begin
                diff_q <= {item_i.sample[31], item_i.sample}
                        - {cfg_i.left_edge[31], cfg_i.left_edge};
                if (item_i.sample < min_q) min_q <= item_i.sample;
                if (item_i.sample > max_q) max_q <= item_i.sample;
                state_q <= ST_MUL;
              end
              hbe_pkg::OP_READ: begin
                cprod_q    <= 38'(item_i.bin_index) * 38'(cfg_i.bin_step);
                in_range_q <= (32'(item_i.bin_index) < MAX_BINS);
                state_q    <= ST_RMW;
              end
              hbe_pkg::OP_CLEAR: begin
                below_q   <= '0;
                above_q   <= '0;
                min_q     <= hbe_pkg::S32_MAX;
                max_q     <= hbe_pkg::S32_MIN;
                clr_ptr_q <= '0;
                state_q   <= ST_CLR;
              end
              default: begin
                state_q <= ST_AUB;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (diff_q[32]) begin
            below_q <= inc_sat(below_q);
            state_q <= ST_AUB;
          end else begin
            prod_q  <= 63'(diff_q[31:0]) * 63'(cfg_i.inv_bin_step);
            state_q <= ST_IDX;
          end
        end
        ST_IDX: begin
          if (prod_q[62:32] >= 31'(nb)) begin
            above_q <= inc_sat(above_q);
            state_q <= ST_AUB;
          end else begin
            addr_q  <= prod_q[32 +: AW];
            state_q <= ST_RMW;
          end
        end
        ST_RMW: begin
          if (op_q == hbe_pkg::OP_READ) begin
            count_q  <= in_range_q ? cnt_out(rdata_q) : 32'd0;
            center_q <= sat32(center_sum);
          end
          state_q <= ST_AUB;
        end
        ST_AUB: begin
          aprod_q <= 61'(mag) * 61'(hbe_pkg::DIV1000_MAGIC);
          aneg_q  <= range_w[32];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          aub_q   <= sat32(40'(max_q) + q_signed);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_CLR: begin
          clr_ptr_q <= clr_ptr_q + AW'(1);
          if (clr_ptr_q == AW'(MAX_BINS - 1)) begin
            init_q  <= 1'b0;
            state_q <= init_q ? ST_IDLE : ST_AUB;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o             = done_q;
  assign bin_count_o        = count_q;
  assign bin_center_o       = center_q;
  assign below_count_o      = cnt_out(below_q);
  assign above_count_o      = cnt_out(above_q);
  assign data_min_o         = min_q;
  assign data_max_o         = max_q;
  assign auto_upper_bound_o = aub_q;

endmodule

@@ hw/rtl/histogram_binning_engine.sv @@
// Histogram binning engine: fixed-width histogram with outlier counts.
// Depends on hbe_pkg, hbe_front and hbe_back.
//
// Command channel: a word (func, sample, bin_index) is taken at a rising edge
// with start_i high and busy_o low. func: add sample, read bin, clear, or a
// no-op that only reports status. A two-word queue sits between the decoder
// and the sequencer, so up to two words can be taken while one is at work.
// Result channel: every word yields exactly one result, shown for one cycle
// with done_o high. The receiver cannot stall; results are never held back.
// The sequencer works one word at a time. Every word ends in the auto upper
// bound and finish states; before them a read fetches its bin, a clear
// sweeps the bin store, and an add multiplies, compares the index and does a
// read-modify-write of the bin store, or stops after the multiply step (below
// range) or after the index compare (above range).
// Config channel: cfg_valid_i/cfg_ready_o with a register index and data;
// always ready. Write only while no word is in flight.
// Reset: config goes to its defaults and the bin store is swept to zero
// with busy_o high; no result is produced for that sweep.
`timescale 1ns / 1ps

module histogram_binning_engine #(
  parameter int unsigned MAX_BINS   = 128,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    func_i,
  input  logic signed [31:0]            sample_i,
  input  logic [6:0]                    bin_index_i,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  // result channel
  output logic                          done_o,
  output logic [31:0]                   bin_count_o,
  output logic signed [31:0]            bin_center_o,
  output logic [31:0]                   below_count_o,
  output logic [31:0]                   above_count_o,
  output logic signed [31:0]            data_min_o,
  output logic signed [31:0]            data_max_o,
  output logic signed [31:0]            auto_upper_bound_o
);

  hbe_pkg::cfg_t  cfg_q;
  hbe_pkg::item_t item;
  logic           item_valid;
  logic           item_ready;
  logic           init_busy;

  // Register file is always ready; out-of-list indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge    <= hbe_pkg::RST_LEFT_EDGE;
      cfg_q.bin_step     <= hbe_pkg::RST_BIN_STEP;
      cfg_q.inv_bin_step <= hbe_pkg::RST_INV_WIDTH;
      cfg_q.bins_in_use  <= hbe_pkg::RST_BINS_IN_USE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hbe_pkg::CFG_LEFT_EDGE:   cfg_q.left_edge    <= cfg_data_i;
        hbe_pkg::CFG_BIN_STEP:    cfg_q.bin_step     <= cfg_data_i[30:0];
        hbe_pkg::CFG_INV_WIDTH:   cfg_q.inv_bin_step <= cfg_data_i[30:0];
        hbe_pkg::CFG_BINS_IN_USE: cfg_q.bins_in_use  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Decoder and command queue.
  hbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .func_i       (func_i),
    .sample_i     (sample_i),
    .bin_index_i  (bin_index_i),
    .hold_i       (init_busy),
    .busy_o       (busy_o),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Sequencer with the bin store and status registers.
  hbe_back #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .item_i             (item),
    .item_valid_i       (item_valid),
    .item_ready_o       (item_ready),
    .init_busy_o        (init_busy),
    .done_o             (done_o),
    .bin_count_o        (bin_count_o),
    .bin_center_o       (bin_center_o),
    .below_count_o      (below_count_o),
    .above_count_o      (above_count_o),
    .data_min_o         (data_min_o),
    .data_max_o         (data_max_o),
    .auto_upper_bound_o (auto_upper_bound_o)
  );

endmodule

@@ hw/rtl/hbe_checker.sv @@
// Port-level checker for the histogram binning engine, bound to the top.
// Depends on histogram_binning_engine_macros.svh and the top level.
`timescale 1ns / 1ps
`include "histogram_binning_engine_macros.svh"

module hbe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               done_o,
  input logic signed [31:0] data_min_o,
  input logic signed [31:0] data_max_o,
  input logic signed [31:0] auto_upper_bound_o
);

  // The sequencer returns to idle after each result, so strobes never touch.
  `HBE_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held two cycles")

  // Extremes are either both at their empty values or ordered.
  `HBE_ASSERT(a_extremes_ordered, done_o |-> (data_min_o <= data_max_o) || ((data_min_o == 32'sh7FFF_FFFF) && (data_max_o == 32'sh8000_0000)), "min above max with data present")

  // With no data the auto bound saturates low.
  `HBE_ASSERT(a_empty_bound, done_o && (data_min_o > data_max_o) |-> auto_upper_bound_o == 32'sh8000_0000, "auto bound wrong on empty data")

  // With data the auto bound never lies below the maximum.
  `HBE_ASSERT(a_bound_above_max, done_o && (data_min_o <= data_max_o) |-> auto_upper_bound_o >= data_max_o, "auto bound below max")

endmodule

bind histogram_binning_engine hbe_checker u_hbe_checker (.*);
